### sv/bthalloc_pkg.sv
// Package for the boundary-tag heap allocator core.
// Holds heap geometry constants, status codes and the tag word helpers.
// Used by all modules of the block; depends on nothing.
`timescale 1ns / 1ps
package bthalloc_pkg;

  localparam int unsigned PageBytes  = 4096;
  localparam int unsigned HeapBytes  = 32768;
  localparam int unsigned HeapWords  = HeapBytes / 4;
  localparam int unsigned WordAw     = $clog2(HeapWords);
  localparam int unsigned AddrW      = $clog2(HeapBytes);
  // Sizes and positions get two spare bits so sums of two never wrap.
  localparam int unsigned SumW       = AddrW + 2;

  localparam logic [SumW-1:0] FirstHeader = SumW'(4);
  localparam logic [SumW-1:0] InitSize    = SumW'(PageBytes - 8);
  localparam logic [SumW-1:0] InitEnd     = SumW'(PageBytes - 1);
  localparam logic [SumW-1:0] PageSz      = SumW'(PageBytes);
  localparam logic [SumW-1:0] HeapSz      = SumW'(HeapBytes);
  localparam logic [31:0]     SizeMask    = 32'hFFFF_FFFE;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNoRoom  = 2'd1,
    StBadFree = 2'd2
  } status_e;

  localparam logic FuncAlloc = 1'b0;

  // Size field of a stored tag, clipped to the working width.
  function automatic logic [SumW-1:0] tag_size(input logic [31:0] w);
    logic [31:0] m;
    m = w & SizeMask;
    return (m[31:SumW] != '0) ? {SumW{1'b1}} & ~SumW'(1) : m[SumW-1:0];
  endfunction

  function automatic logic [31:0] mk_tag(input logic [SumW-1:0] sz, input logic used);
    return {{(32-SumW){1'b0}}, sz[SumW-1:1], used};
  endfunction

endpackage

### sv/bthalloc_ram.sv
// Single-port heap word memory with a registered read.
// Depends on bthalloc_pkg for its depth.
`timescale 1ns / 1ps
module bthalloc_ram (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [bthalloc_pkg::WordAw-1:0]  addr_i,
  input  logic [31:0]                      wdata_i,
  output logic [31:0]                      rdata_o
);
  import bthalloc_pkg::*;

  logic [31:0] mem [HeapWords];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

### sv/boundary_tag_heap_allocator_core.sv
// Top level of the boundary-tag heap allocator core.
// Holds the request sequencer; depends on bthalloc_pkg and bthalloc_ram.
`timescale 1ns / 1ps
// The core manages a 32 KiB byte-addressed heap as an implicit list of
// blocks with boundary tags, served first-fit.
// A request is taken at a clock edge where start_i is high and busy_o is
// low. func_i selects allocate (request_size_i) or free (free_address_i).
// Exactly one result follows: payload_address_o and status_o are valid for
// the single cycle in which done_o is high. The receiver cannot stall, and
// the core never waits on it.
// Every heap word goes through one memory port with a registered read,
// so each read takes a read state and a check state. An allocate walks
// block headers in turn, may grow the heap by a page and splits a larger
// block; a free reads its header and, where present, the next header, the
// previous footer and header, then writes merged tags. Refusals go to done.
// One request is in work at a time; busy_o is high from acceptance until
// the cycle of done_o.
// Reset clears the sequencer, sets the heap end to one page and then runs
// a single write that places the first free header; busy_o is high for that
// one cycle. No other word is cleared.
module boundary_tag_heap_allocator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              func_i,
  input  logic [11:0]                       request_size_i,
  input  logic [14:0]                       free_address_i,
  output logic                              done_o,
  output logic [14:0]                       payload_address_o,
  output logic [1:0]                        status_o
);
  import bthalloc_pkg::*;

  typedef enum logic [4:0] {
    SInit, SIdle,
    // allocate walk
    SAWalkRd, SAWalkChk,
    SAGrowRd, SAGrowChk, SAGrowW1, SAGrowW2,
    SGrant1, SGrant2, SGrant3, SGrant4,
    // free
    SFHdrRd, SFHdrChk, SFNxtRd, SFNxtChk, SFPsRd, SFPsChk, SFPvRd, SFPvChk,
    SFW1, SFW2,
    SDone
  } state_e;

  state_e            state_q;
  logic [SumW-1:0]   end_q;      // heap_end_address
  logic [SumW-1:0]   b_q, bs_q, req_q;
  logic [SumW-1:0]   nxt_q, ns_q, prv_q, ps_q;
  logic              req_last_q, next_free_q, next_last_q, prev_free_q;
  logic              rd_wait_q;  // used bit of the last block while growing
  logic [1:0]        st_q;
  logic [14:0]       addr_q;

  logic              we;
  logic [SumW-1:0]   ma;          // byte address to the memory
  logic [31:0]       wd;
  logic [31:0]       rd;
  logic [SumW-1:0]   lim;
  logic [SumW-1:0]   rsz;
  logic              rused;
  logic [SumW-1:0]   reqd;

  assign lim   = end_q - SumW'(3);
  assign rsz   = tag_size(rd);
  assign rused = rd[0];
  assign reqd  = ((SumW'(request_size_i) + SumW'(7)) & ~SumW'(7)) + SumW'(8);

  // Memory port: address and write data picked by state.
  always_comb begin
    we = 1'b0;
    ma = b_q;
    wd = '0;
    unique case (state_q)
      SInit: begin
        we = 1'b1; ma = FirstHeader; wd = mk_tag(InitSize, 1'b0);
      end
      SAWalkRd, SAWalkChk, SAGrowRd, SAGrowChk, SFHdrRd, SFHdrChk: ma = b_q;
      SFNxtRd, SFNxtChk: ma = nxt_q;
      SFPsRd, SFPsChk:   ma = b_q - SumW'(4);
      SFPvRd, SFPvChk:   ma = prv_q;
      SAGrowW1: begin
        we = 1'b1; ma = b_q + bs_q - SumW'(4); wd = mk_tag(bs_q, 1'b1);
      end
      SAGrowW2: begin
        we = 1'b1; ma = b_q; wd = mk_tag(bs_q, 1'b0);
      end
      SGrant1: begin
        we = 1'b1; ma = b_q;
        wd = (bs_q > req_q) ? mk_tag(req_q, 1'b1) : mk_tag(bs_q, 1'b1);
      end
      SGrant2: begin
        we = 1'b1;
        if (bs_q > req_q) begin
          ma = b_q + req_q - SumW'(4); wd = mk_tag(req_q, 1'b1);
        end else begin
          we = (b_q + bs_q != lim);
          ma = b_q + bs_q - SumW'(4); wd = mk_tag(bs_q, 1'b1);
        end
      end
      SGrant3: begin
        we = 1'b1; ma = b_q + req_q; wd = mk_tag(bs_q - req_q, 1'b0);
      end
      SGrant4: begin
        we = (b_q + bs_q != lim);
        ma = b_q + bs_q - SumW'(4); wd = mk_tag(bs_q - req_q, 1'b0);
      end
      SFW1: begin
        // Header of the merged free block.
        we = 1'b1;
        ma = prev_free_q ? prv_q : b_q;
        wd = mk_tag((prev_free_q ? ps_q : '0) + bs_q + (next_free_q ? ns_q : '0), 1'b0);
      end
      SFW2: begin
        // Footer, skipped when the merged block is the last one.
        we = next_free_q ? !next_last_q : !req_last_q;
        ma = next_free_q ? nxt_q + ns_q - SumW'(4) : b_q + bs_q - SumW'(4);
        wd = mk_tag((prev_free_q ? ps_q : '0) + bs_q + (next_free_q ? ns_q : '0), 1'b0);
      end
      default: ;
    endcase
    // Words beyond the heap are neither written nor meaningful.
    if (ma[SumW-1:AddrW] != '0) we = 1'b0;
  end

  bthalloc_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (ma[AddrW-1:2]),
    .wdata_i (wd),
    .rdata_o (rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SInit;
      end_q       <= InitEnd;
      st_q        <= StOk;
      addr_q      <= '0;
      b_q         <= '0;
      bs_q        <= '0;
      req_q       <= '0;
      nxt_q       <= '0;
      ns_q        <= '0;
      prv_q       <= '0;
      ps_q        <= '0;
      req_last_q  <= 1'b0;
      next_free_q <= 1'b0;
      next_last_q <= 1'b0;
      prev_free_q <= 1'b0;
      rd_wait_q   <= 1'b0;
    end else begin
      unique case (state_q)
        SInit: state_q <= SIdle;
        SIdle: begin
          if (start_i) begin
            st_q   <= StOk;
            addr_q <= '0;
            if (func_i == FuncAlloc) begin
              req_q <= reqd;
              b_q   <= FirstHeader;
              if (request_size_i == '0 || SumW'(request_size_i) >= PageSz - SumW'(8)) begin
                st_q <= StNoRoom; state_q <= SDone;
              end else begin
                state_q <= SAWalkRd;
              end
            end else begin
              b_q <= SumW'(free_address_i) - SumW'(4);
              if (free_address_i == '0 || free_address_i[2:0] != '0 ||
                  SumW'(free_address_i) > end_q) begin
                st_q <= StBadFree; state_q <= SDone;
              end else begin
                state_q <= SFHdrRd;
              end
            end
          end
        end
        SAWalkRd: state_q <= SAWalkChk;
        SAWalkChk: begin
          bs_q <= rsz;
          if (rsz < SumW'(8) || b_q + rsz > lim) begin
            st_q <= StNoRoom; state_q <= SDone;
          end else if (!rused && rsz >= req_q) begin
            state_q <= SGrant1;
          end else if (b_q + rsz == lim) begin
            if (end_q + SumW'(1) + PageSz > HeapSz) begin
              st_q <= StNoRoom; state_q <= SDone;
            end else begin
              rd_wait_q <= rused;
              state_q <= SAGrowChk;
            end
          end else begin
            b_q <= b_q + rsz; state_q <= SAWalkRd;
          end
        end
        SAGrowChk: begin
          // rd_wait_q holds the used bit of the last block.
          end_q <= end_q + PageSz;
          if (rd_wait_q) begin
            state_q <= SAGrowW1;
          end else begin
            bs_q <= bs_q + PageSz; state_q <= SAGrowW2;
          end
        end
        SAGrowW1: begin
          b_q <= end_q - PageSz - SumW'(3);
          bs_q <= PageSz;
          state_q <= SAGrowW2;
        end
        SAGrowW2: begin
          if (bs_q < req_q) begin
            st_q <= StNoRoom; state_q <= SDone;
          end else begin
            state_q <= SGrant1;
          end
        end
        SAGrowRd: state_q <= SDone;
        SGrant1: state_q <= SGrant2;
        SGrant2: state_q <= (bs_q > req_q) ? SGrant3 : SDone;
        SGrant3: state_q <= SGrant4;
        SGrant4: state_q <= SDone;
        SFHdrRd: state_q <= SFHdrChk;
        SFHdrChk: begin
          bs_q <= rsz;
          req_last_q  <= (b_q + rsz == lim);
          next_free_q <= 1'b0;
          next_last_q <= 1'b0;
          prev_free_q <= 1'b0;
          nxt_q <= b_q + rsz;
          if (!rused || rsz < SumW'(8) || b_q + rsz > lim) begin
            st_q <= StBadFree; state_q <= SDone;
          end else if (b_q + rsz != lim) begin
            state_q <= SFNxtRd;
          end else begin
            state_q <= (b_q != FirstHeader) ? SFPsRd : SFW1;
          end
        end
        SFNxtRd: state_q <= SFNxtChk;
        SFNxtChk: begin
          ns_q <= rsz;
          if (rsz >= SumW'(8) && nxt_q + rsz <= lim) begin
            next_free_q <= !rused;
            next_last_q <= (nxt_q + rsz == lim);
          end
          state_q <= (b_q != FirstHeader) ? SFPsRd : SFW1;
        end
        SFPsRd: state_q <= SFPsChk;
        SFPsChk: begin
          ps_q  <= rsz;
          prv_q <= b_q - rsz;
          state_q <= (rsz >= SumW'(8) && rsz + FirstHeader <= b_q) ? SFPvRd : SFW1;
        end
        SFPvRd: state_q <= SFPvChk;
        SFPvChk: begin
          prev_free_q <= !rused;
          state_q <= SFW1;
        end
        SFW1: state_q <= SFW2;
        SFW2: state_q <= SDone;
        SDone: state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
      if (state_q == SGrant1) begin
        addr_q <= 15'(b_q + SumW'(4));
      end
    end
  end

  assign busy_o            = (state_q != SIdle);
  assign done_o            = (state_q == SDone);
  assign payload_address_o = (st_q == StOk) ? addr_q : '0;
  assign status_o          = st_q;

endmodule
